// File: rtl/core/int_mul_div_rem_unit_defines.svh
// ----------------------------------------------------------------------------
// int_mul_div_rem_unit_defines.svh
// Assertion macros shared by the multiply/divide unit.
// ----------------------------------------------------------------------------
`ifndef INT_MUL_DIV_REM_UNIT_DEFINES_SVH
`define INT_MUL_DIV_REM_UNIT_DEFINES_SVH

// same-cycle implication
`define IMDR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define IMDR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/imdr_pkg.sv
// ----------------------------------------------------------------------------
// imdr_pkg
// Types and codes for the integer multiply/divide/remainder unit.
// ----------------------------------------------------------------------------
package imdr_pkg;

   typedef enum logic [1:0] {
      MODE_MUL_LO = 2'd0,
      MODE_DIV_S  = 2'd1,
      MODE_REM_S  = 2'd2,
      MODE_DIV_U  = 2'd3
   } imdr_mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CALC,
      ST_FINISH
   } imdr_state_type;

endpackage

// File: rtl/core/int_mul_div_rem_unit.sv
// ----------------------------------------------------------------------------
// int_mul_div_rem_unit
// Iterative integer multiply (low half), signed/unsigned divide and signed remainder.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel req_*: a beat carries req_mode, req_operand_a, req_operand_b.
//   It is taken when req_valid is high and req_stall is low. req_stall is high
//   from the accepting edge until the unit returns to idle.
//   Result channel rsp_*: rsp_result is held in an output register while
//   rsp_valid is high and rsp_stall is high.
// Timing:
//   One shared adder does one step per cycle: a shift-add for multiply or a
//   restoring subtract for divide, DATA_WIDTH steps in all. The finish step
//   then loads the result into the output register, and the next beat is
//   taken only once the unit is back in idle, so beats do not overlap.
//   A stalled receiver holds the finished result in the finish step; a new
//   beat is taken while the previous result still waits in the output register.
// Reset: synchronous, active high; clears the sequencer and rsp_valid.
// Divide by zero gives 0; the most-negative quotient wraps.
// ----------------------------------------------------------------------------
`include "int_mul_div_rem_unit_defines.svh"

module int_mul_div_rem_unit
   import imdr_pkg::*;
#(
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_mode,
   input  logic [DATA_WIDTH-1:0] req_operand_a,
   input  logic [DATA_WIDTH-1:0] req_operand_b,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [DATA_WIDTH-1:0] rsp_result
);

   localparam int W     = DATA_WIDTH;
   localparam int CNT_W = $clog2(DATA_WIDTH);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_WIDTH - 1);

   imdr_state_type  state_ff, state_in;
   imdr_mode_type   mode_ff, mode_in;
   logic [W-1:0]    acc_ff, acc_in;
   logic [W-1:0]    opa_ff, opa_in;
   logic [W-1:0]    opb_ff, opb_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic            neg_q_ff, neg_q_in;
   logic            neg_r_ff, neg_r_in;
   logic            zero_ff, zero_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [W-1:0]    rsp_result_ff, rsp_result_in;

   logic            req_accept;
   logic            out_free;
   logic            sign_a, sign_b;
   logic [W-1:0]    abs_a, abs_b;
   imdr_mode_type   req_mode_t;

   // shared adder
   logic [W:0]      add_x, add_y;
   logic            add_sub;
   logic [W+1:0]    add_sum;
   logic            ge;
   logic [W-1:0]    final_val;

   assign req_mode_t = imdr_mode_type'(req_mode);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign sign_a     = req_operand_a[W-1];
   assign sign_b     = req_operand_b[W-1];
   assign abs_a      = sign_a ? (~req_operand_a + W'(1)) : req_operand_a;
   assign abs_b      = sign_b ? (~req_operand_b + W'(1)) : req_operand_b;

   always_comb begin
      if (mode_ff == MODE_MUL_LO) begin
         add_x   = {1'b0, acc_ff};
         add_y   = {1'b0, opa_ff};
         add_sub = 1'b0;
      end else begin
         add_x   = {acc_ff, opa_ff[W-1]};
         add_y   = {1'b0, opb_ff};
         add_sub = 1'b1;
      end
   end

   assign add_sum = {1'b0, add_x} + {1'b0, add_y ^ {(W+1){add_sub}}} + (W+2)'(add_sub);
   assign ge      = add_sum[W+1];

   always_comb begin
      unique case (mode_ff)
         MODE_MUL_LO: final_val = acc_ff;
         MODE_DIV_S:  final_val = zero_ff ? '0 : (neg_q_ff ? (~opa_ff + W'(1)) : opa_ff);
         MODE_REM_S:  final_val = zero_ff ? '0 : (neg_r_ff ? (~acc_ff + W'(1)) : acc_ff);
         MODE_DIV_U:  final_val = zero_ff ? '0 : opa_ff;
         default:     final_val = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff       <= mode_in;
      acc_ff        <= acc_in;
      opa_ff        <= opa_in;
      opb_ff        <= opb_in;
      cnt_ff        <= cnt_in;
      neg_q_ff      <= neg_q_in;
      neg_r_ff      <= neg_r_in;
      zero_ff       <= zero_in;
      rsp_result_ff <= rsp_result_in;
   end

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      acc_in        = acc_ff;
      opa_in        = opa_ff;
      opb_in        = opb_ff;
      cnt_in        = cnt_ff;
      neg_q_in      = neg_q_ff;
      neg_r_in      = neg_r_ff;
      zero_in       = zero_ff;
      rsp_result_in = rsp_result_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      req_stall     = 1'b1;

      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               mode_in  = req_mode_t;
               acc_in   = '0;
               cnt_in   = '0;
               neg_q_in = sign_a ^ sign_b;
               neg_r_in = sign_a;
               zero_in  = (req_operand_b == '0);
               case (req_mode_t) inside
                  MODE_DIV_S, MODE_REM_S: begin
                     opa_in = abs_a;
                     opb_in = abs_b;
                  end
                  default: begin
                     opa_in = req_operand_a;
                     opb_in = req_operand_b;
                  end
               endcase
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            if (mode_ff == MODE_MUL_LO) begin
               if (opb_ff[0]) begin
                  acc_in = add_sum[W-1:0];
               end
               opa_in = {opa_ff[W-2:0], 1'b0};
               opb_in = {1'b0, opb_ff[W-1:1]};
            end else begin
               acc_in = ge ? add_sum[W-1:0] : add_x[W-1:0];
               opa_in = {opa_ff[W-2:0], ge};
            end
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_LAST) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_result_in = final_val;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_result_ff;

   `IMDR_ASSERT_NEXT(a_accept_starts, clock, reset, req_accept,
      state_ff == ST_CALC && cnt_ff == '0, "accepted beat did not start iteration")
   `IMDR_ASSERT_NEXT(a_calc_ends, clock, reset, state_ff == ST_CALC && cnt_ff == CNT_LAST,
      state_ff == ST_FINISH, "iteration did not end after last step")
   `IMDR_ASSERT_NEXT(a_finish_loads, clock, reset, state_ff == ST_FINISH && out_free,
      rsp_valid && state_ff == ST_IDLE, "finished result not loaded")
   `IMDR_ASSERT_NEXT(a_div_zero, clock, reset,
      state_ff == ST_FINISH && out_free && zero_ff && mode_ff != MODE_MUL_LO,
      rsp_result == '0, "divide by zero gave nonzero result")

endmodule
